// ----- hdl/srgbxy_pkg.sv -----
// Package with payload types, matrix constants and the sRGB linearization table builder.
package srgbxy_pkg;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} srgbxy_in_t;

	typedef struct packed {
		logic [15:0] chroma_x;
		logic [15:0] chroma_y;
		logic        black_flag;
	} srgbxy_out_t;

	// Matrix coefficients scaled by 10000; all fit in 14 bits.
	localparam int CoefW = 14;
	localparam int XR = 4124;
	localparam int XG = 3576;
	localparam int XB = 1805;
	localparam int YR = 2126;
	localparam int YG = 7152;
	localparam int YB = 722;
	localparam int SR = 6443;
	localparam int SG = 11920;
	localparam int SB = 12032;

	// Linear values in Q30; the top code reaches exactly 2^30, hence 31 bits.
	typedef logic [30:0] q30_tab_t [256];

	function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
		logic [63:0] p;
		p = a * b;
		return p >> 30;
	endfunction

	// Only evaluated at elaboration to build the constant table.
	function automatic logic [63:0] lin_q30(int c);
		logic [63:0] u;
		logic [63:0] w;
		logic [63:0] v;
		logic [63:0] cand;
		logic [63:0] sq;
		logic [63:0] p5;
		logic [63:0] cc;
		cc = 64'(c);
		if (c <= 10) begin
			return ((64'd100 * cc) << 30) / 64'd329460;
		end
		u = ((64'd1000 * cc + 64'd14025) << 30) / 64'd269025;
		w = qmul(u, u);
		v = 64'd0;
		for (int bit_i = 30; bit_i >= 0; bit_i--) begin
			cand = v | (64'd1 << bit_i);
			sq = qmul(cand, cand);
			p5 = qmul(qmul(sq, sq), cand);
			if (cand <= (64'd1 << 30) && p5 <= w) begin
				v = cand;
			end
		end
		return qmul(w, v);
	endfunction

	function automatic q30_tab_t lin_tab();
		q30_tab_t t;
		logic [63:0] e;
		for (int c = 0; c < 256; c++) begin
			e = lin_q30(c);
			t[c] = e[30:0];
		end
		return t;
	endfunction

endpackage

// ----- hdl/srgbxy_div_cell.sv -----
// One restoring-division cell: produces one quotient bit for both x and y per stage.
module srgbxy_div_cell #(
	parameter int SW = 42,
	parameter int QW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_in,
	output logic          ready_in,
	input  logic [SW-1:0] rx_in,
	input  logic [SW-1:0] ry_in,
	input  logic [SW-1:0] den_in,
	input  logic [QW-1:0] qx_in,
	input  logic [QW-1:0] qy_in,
	input  logic          black_in,
	output logic          valid_q,
	input  logic          ready_out,
	output logic [SW-1:0] rx_q,
	output logic [SW-1:0] ry_q,
	output logic [SW-1:0] den_q,
	output logic [QW-1:0] qx_q,
	output logic [QW-1:0] qy_q,
	output logic          black_q
);
	logic [SW:0] tx;
	logic [SW:0] ty;
	logic [SW:0] dd;
	logic        gex;
	logic        gey;
	logic [SW:0] nx;
	logic [SW:0] ny;

	// The remainder stays below the divisor, so the result fits back into SW bits.
	always_comb begin
		tx  = {rx_in, 1'b0};
		ty  = {ry_in, 1'b0};
		dd  = {1'b0, den_in};
		gex = tx >= dd;
		gey = ty >= dd;
		nx  = gex ? tx - dd : tx;
		ny  = gey ? ty - dd : ty;
	end

	assign ready_in = !valid_q || ready_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_in) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_in && valid_in) begin
			rx_q    <= nx[SW-1:0];
			ry_q    <= ny[SW-1:0];
			den_q   <= den_in;
			qx_q    <= {qx_in[QW-2:0], gex};
			qy_q    <= {qy_in[QW-2:0], gey};
			black_q <= black_in;
		end
	end
endmodule

// ----- hdl/srgb_to_cie_xy_chromaticity.sv -----
// Top level of the sRGB (D65) pixel to CIE xy chromaticity converter.
// This block converts one 8-bit gamma-encoded sRGB pixel per clock cycle, unless a stall
// holds the pipeline, into CIE x and y chromaticity, each an unsigned fraction with
// OUT_FRAC_BITS fraction bits, truncated and delivered in a 16-bit field (the low 16 bits
// of the quotient). Each channel is linearized through a constant 256-entry sRGB transfer
// table with LIN_FRAC_BITS fraction bits, the matrix products X, Y and X+Y+Z are formed in
// the second stage, and the two divisions run through a row of OUT_FRAC_BITS identical
// restoring-division cells, one quotient bit per cell. A pixel passes through the stage 1
// and stage 2 registers and then the cells, the last of which is the output register. Each
// stage holds its data only while it is occupied and the stage after it is stalled, so
// empty stages keep absorbing pixels while a finished result waits on out_stall. A black
// pixel, or one whose linear values truncate to zero, yields x = y = 0 with black_flag set.
module srgb_to_cie_xy_chromaticity #(
	parameter int OUT_FRAC_BITS = 16,
	parameter int LIN_FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  srgbxy_pkg::srgbxy_in_t    in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output srgbxy_pkg::srgbxy_out_t   out_data
);
	import srgbxy_pkg::*;

	// Linear value width: the top code reaches exactly 1.0.
	localparam int LW = LIN_FRAC_BITS + 1;
	// Sum of three 14-bit by LW-bit products.
	localparam int SW = LW + CoefW + 2;
	localparam int QW = OUT_FRAC_BITS;
	localparam q30_tab_t LinTab = lin_tab();

	// Stage 1: table lookup of the three channels.
	logic          v_s1;
	logic          rdy_s1;
	logic [LW-1:0] r_s1;
	logic [LW-1:0] g_s1;
	logic [LW-1:0] b_s1;

	// Stage 2: matrix products and their sum.
	logic          v_s2;
	logic          rdy_s2;
	logic [SW-1:0] bx_s2;
	logic [SW-1:0] by_s2;
	logic [SW-1:0] sum_s2;

	// Division row; index 0 is fed from stage 2.
	logic          cv    [QW+1];
	logic          crdy  [QW+1];
	logic [SW-1:0] crx   [QW+1];
	logic [SW-1:0] cry   [QW+1];
	logic [SW-1:0] cden  [QW+1];
	logic [QW-1:0] cqx   [QW+1];
	logic [QW-1:0] cqy   [QW+1];
	logic          cblk  [QW+1];

	// A stage can take new data when it is empty or the next stage moves on.
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign rdy_s2   = !v_s2 || crdy[0];
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			r_s1 <= LinTab[in_data.red_in][30 -: LW];
			g_s1 <= LinTab[in_data.green_in][30 -: LW];
			b_s1 <= LinTab[in_data.blue_in][30 -: LW];
		end
		if (rdy_s2 && v_s1) begin
			bx_s2  <= SW'(XR) * SW'(r_s1) + SW'(XG) * SW'(g_s1) + SW'(XB) * SW'(b_s1);
			by_s2  <= SW'(YR) * SW'(r_s1) + SW'(YG) * SW'(g_s1) + SW'(YB) * SW'(b_s1);
			sum_s2 <= SW'(SR) * SW'(r_s1) + SW'(SG) * SW'(g_s1) + SW'(SB) * SW'(b_s1);
		end
	end

	// X and Y never exceed the sum, so the first remainder is the numerator itself.
	assign cv[0]   = v_s2;
	assign crx[0]  = bx_s2;
	assign cry[0]  = by_s2;
	assign cden[0] = sum_s2;
	assign cqx[0]  = '0;
	assign cqy[0]  = '0;
	assign cblk[0] = (sum_s2 == '0);
	assign crdy[QW] = !out_stall;

	for (genvar i = 0; i < QW; i++) begin : g_cell
		srgbxy_div_cell #(
			.SW(SW),
			.QW(QW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_in (cv[i]),
			.ready_in (crdy[i]),
			.rx_in    (crx[i]),
			.ry_in    (cry[i]),
			.den_in   (cden[i]),
			.qx_in    (cqx[i]),
			.qy_in    (cqy[i]),
			.black_in (cblk[i]),
			.valid_q  (cv[i+1]),
			.ready_out(crdy[i+1]),
			.rx_q     (crx[i+1]),
			.ry_q     (cry[i+1]),
			.den_q    (cden[i+1]),
			.qx_q     (cqx[i+1]),
			.qy_q     (cqy[i+1]),
			.black_q  (cblk[i+1])
		);
	end

	// The last cell is the output register; a zero divisor fills the quotient with ones,
	// so black pixels are forced to zero here.
	logic [15:0] qx16;
	logic [15:0] qy16;

	if (QW >= 16) begin : g_wide
		assign qx16 = cqx[QW][15:0];
		assign qy16 = cqy[QW][15:0];
	end else begin : g_narrow
		assign qx16 = 16'(cqx[QW]);
		assign qy16 = 16'(cqy[QW]);
	end

	assign out_valid           = cv[QW];
	assign out_data.chroma_x   = cblk[QW] ? 16'd0 : qx16;
	assign out_data.chroma_y   = cblk[QW] ? 16'd0 : qy16;
	assign out_data.black_flag = cblk[QW];
endmodule
